// ===== rtl/core/gmc_pkg.sv =====
// shared types, constants and helpers for the grid max-cost query block
package gmc_pkg;

  // defaults for the top-level parameters
  localparam int MAX_SIDE_DEF         = 256;
  localparam int MAX_CELLS_DEF        = 65536;
  localparam int MAX_RADIUS_CELLS_DEF = 15;

  // fixed field widths
  localparam int DIM_W  = 9;
  localparam int COST_W = 7;
  localparam int RAW_W  = 8;
  localparam int IDX_W  = 2 * DIM_W;
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [COST_W-1:0] LETHAL_COST = 7'd100;
  localparam logic [RAW_W-1:0]  UNKNOWN_RAW = 8'hFF;

  // register indexes (word address bits)
  localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [2:0] REG_ORIGIN_X    = 3'd2;
  localparam logic [2:0] REG_ORIGIN_Y    = 3'd3;
  localparam logic [2:0] REG_COS_YAW     = 3'd4;
  localparam logic [2:0] REG_SIN_YAW     = 3'd5;
  localparam logic [2:0] REG_INV_RES     = 3'd6;

  localparam logic signed [15:0] COS_RESET = 16'sd16384;

  typedef struct packed {
    logic [DIM_W-1:0]   grid_width;
    logic [DIM_W-1:0]   grid_height;
    logic signed [31:0] origin_x_pos;
    logic signed [31:0] origin_y_pos;
    logic signed [15:0] cos_yaw;
    logic signed [15:0] sin_yaw;
    logic [31:0]        inverse_resolution;
  } cfg_t;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_CAPTURE,
    CMD_SUB,
    CMD_M1,
    CMD_M2,
    CMD_M3,
    CMD_M4,
    CMD_M5,
    CMD_M6,
    CMD_M7,
    CMD_M8,
    CMD_M9,
    CMD_M10,
    CMD_M11,
    CMD_CHECK,
    CMD_SCAN,
    CMD_RESULT
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic off_map;
    logic scan_last;
  } dp_stat_t;

  // raw signed cell value to clamped cost, unknown counts as lethal
  function automatic logic [COST_W-1:0] clamp_cost(input logic [RAW_W-1:0] raw);
    logic [COST_W-1:0] res;
    if (raw[RAW_W-1]) begin
      res = LETHAL_COST;
    end else if (raw > {1'b0, LETHAL_COST}) begin
      res = LETHAL_COST;
    end else begin
      res = raw[COST_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/grid_max_cost_in_radius_unit.sv =====
// top level: configuration registers, stream ports, controller and datapath
//
// Grid max-cost query unit. The in_ stream carries one request per beat:
// in_tuser = 0 loads one cell of the store, in_tuser = 1 asks for the
// largest clamped cost over a disk around a world point. A load gives no
// result; a query gives one 7-bit cost on the out_ stream.
// Map geometry and pose are to be written through the cfg_ APB port only
// while the unit is idle; the block itself does not enforce this.
// A load leaves the unit ready for the next request. A query is worked on
// with the input closed, r being the radius in cells (at most
// MAX_RADIUS_CELLS): 13 transform steps, nine of them through the one shared
// 34x34 multiplier, then one store read per cell of the (2r+1)^2 square on
// the single read port, plus a three-stage scan pipeline. A point off the map
// or an invalid grid skips the scan.
// After reset the unit sweeps the store to unknown, one cell per cycle,
// with in_tready low; config writes are taken throughout.
// A finished result waits in the output register; the next request is
// taken meanwhile, and a second result waits until the first is taken.
module grid_max_cost_in_radius_unit #(
  parameter int MAX_SIDE         = gmc_pkg::MAX_SIDE_DEF,
  parameter int MAX_CELLS        = gmc_pkg::MAX_CELLS_DEF,
  parameter int MAX_RADIUS_CELLS = gmc_pkg::MAX_RADIUS_CELLS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [gmc_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [gmc_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [gmc_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // cell_index[15:0], cell_value[23:16], world_x[55:24], world_y[87:56], radius[119:88]
  input  logic [119:0]                in_tdata,
  // opcode[0]
  input  logic                        in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // cost[6:0], zero[7]
  output logic [7:0]                  out_tdata
);
  import gmc_pkg::*;

  cfg_t      cfg_r;
  dp_cmd_t   cmd;
  dp_stat_t  stat;
  logic [COST_W-1:0] cost;
  logic      wr;
  logic [2:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[4:2];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_width         <= '0;
      cfg_r.grid_height        <= '0;
      cfg_r.origin_x_pos       <= '0;
      cfg_r.origin_y_pos       <= '0;
      cfg_r.cos_yaw            <= COS_RESET;
      cfg_r.sin_yaw            <= '0;
      cfg_r.inverse_resolution <= '0;
    end else if (wr) begin
      case (reg_idx)
        REG_GRID_WIDTH:  cfg_r.grid_width         <= cfg_pwdata[DIM_W-1:0];
        REG_GRID_HEIGHT: cfg_r.grid_height        <= cfg_pwdata[DIM_W-1:0];
        REG_ORIGIN_X:    cfg_r.origin_x_pos       <= cfg_pwdata;
        REG_ORIGIN_Y:    cfg_r.origin_y_pos       <= cfg_pwdata;
        REG_COS_YAW:     cfg_r.cos_yaw            <= cfg_pwdata[15:0];
        REG_SIN_YAW:     cfg_r.sin_yaw            <= cfg_pwdata[15:0];
        REG_INV_RES:     cfg_r.inverse_resolution <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      REG_GRID_WIDTH:  cfg_prdata = {23'd0, cfg_r.grid_width};
      REG_GRID_HEIGHT: cfg_prdata = {23'd0, cfg_r.grid_height};
      REG_ORIGIN_X:    cfg_prdata = cfg_r.origin_x_pos;
      REG_ORIGIN_Y:    cfg_prdata = cfg_r.origin_y_pos;
      REG_COS_YAW:     cfg_prdata = {{16{cfg_r.cos_yaw[15]}}, cfg_r.cos_yaw};
      REG_SIN_YAW:     cfg_prdata = {{16{cfg_r.sin_yaw[15]}}, cfg_r.sin_yaw};
      REG_INV_RES:     cfg_prdata = cfg_r.inverse_resolution;
      default:         cfg_prdata = '0;
    endcase
  end

  // controller
  gmc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_opcode  (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  // datapath
  gmc_dp #(
    .MAX_SIDE         (MAX_SIDE),
    .MAX_CELLS        (MAX_CELLS),
    .MAX_RADIUS_CELLS (MAX_RADIUS_CELLS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg        (cfg_r),
    .cell_index (in_tdata[15:0]),
    .cell_value (in_tdata[23:16]),
    .world_x    (in_tdata[55:24]),
    .world_y    (in_tdata[87:56]),
    .radius     (in_tdata[119:88]),
    .stat       (stat),
    .cost       (cost)
  );

  assign out_tdata = {1'b0, cost};

  // reported cost stays within the clamp range
  a_cost_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[6:0] <= LETHAL_COST))
    else $error("cost above lethal");

  // store clearing holds off requests right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("request taken during clearing pass");

  // a query keeps the input closed while it is worked on
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("input open during query");

  // the output padding bit is always zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[7])
    else $error("output pad bit set");

endmodule

// ===== rtl/core/gmc_ctrl.sv =====
// sequencer for clearing, loads, query arithmetic steps and the disk scan
module gmc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_opcode,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output gmc_pkg::dp_cmd_t  cmd,
  input  gmc_pkg::dp_stat_t stat
);
  import gmc_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUB,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_M6,
    ST_M7,
    ST_M8,
    ST_M9,
    ST_M10,
    ST_M11,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  // next state, datapath command and output slot
  always_comb begin
    state_nxt     = state_r;
    cmd           = CMD_NONE;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_CLEAR: begin
        cmd = CMD_CLEAR;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_opcode) begin
            cmd       = CMD_CAPTURE;
            state_nxt = ST_SUB;
          end else begin
            cmd = CMD_LOAD;
          end
        end
      end
      ST_SUB: begin cmd = CMD_SUB; state_nxt = ST_M1; end
      ST_M1:  begin cmd = CMD_M1;  state_nxt = ST_M2; end
      ST_M2:  begin cmd = CMD_M2;  state_nxt = ST_M3; end
      ST_M3:  begin cmd = CMD_M3;  state_nxt = ST_M4; end
      ST_M4:  begin cmd = CMD_M4;  state_nxt = ST_M5; end
      ST_M5:  begin cmd = CMD_M5;  state_nxt = ST_M6; end
      ST_M6:  begin cmd = CMD_M6;  state_nxt = ST_M7; end
      ST_M7:  begin cmd = CMD_M7;  state_nxt = ST_M8; end
      ST_M8:  begin cmd = CMD_M8;  state_nxt = ST_M9; end
      ST_M9:  begin cmd = CMD_M9;  state_nxt = ST_M10; end
      ST_M10: begin cmd = CMD_M10; state_nxt = ST_M11; end
      ST_M11: begin cmd = CMD_M11; state_nxt = ST_CHECK; end
      ST_CHECK: begin
        cmd       = CMD_CHECK;
        state_nxt = stat.off_map ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        cmd = CMD_SCAN;
        if (stat.scan_last) state_nxt = ST_DRAIN1;
      end
      ST_DRAIN1: state_nxt = ST_DRAIN2;
      ST_DRAIN2: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd           = CMD_RESULT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // state and registered output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/gmc_dp.sv =====
// datapath: cell store, shared multiplier, map transform and disk scan pipeline
module gmc_dp #(
  parameter int MAX_SIDE         = gmc_pkg::MAX_SIDE_DEF,
  parameter int MAX_CELLS        = gmc_pkg::MAX_CELLS_DEF,
  parameter int MAX_RADIUS_CELLS = gmc_pkg::MAX_RADIUS_CELLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gmc_pkg::dp_cmd_t              cmd,
  input  gmc_pkg::cfg_t                 cfg,
  input  logic [15:0]                   cell_index,
  input  logic signed [7:0]             cell_value,
  input  logic signed [31:0]            world_x,
  input  logic signed [31:0]            world_y,
  input  logic [31:0]                   radius,
  output gmc_pkg::dp_stat_t             stat,
  output logic [gmc_pkg::COST_W-1:0]    cost
);
  import gmc_pkg::*;

  localparam int AW       = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int RW       = (MAX_RADIUS_CELLS > 0) ? $clog2(MAX_RADIUS_CELLS + 1) : 1;
  localparam int OW       = RW + 1;
  localparam int SIDE_CAP = (MAX_SIDE > 511) ? 511 : MAX_SIDE;
  localparam logic [DIM_W-1:0] SIDE_LIM  = SIDE_CAP[DIM_W-1:0];
  localparam logic [RW-1:0]    RMAX      = MAX_RADIUS_CELLS[RW-1:0];
  localparam logic [24:0]      CELLS_LIM = MAX_CELLS[24:0];
  localparam logic [AW-1:0]    CLR_LAST  = AW'(MAX_CELLS - 1);

  // effective grid size
  logic [DIM_W-1:0] w_eff, h_eff;
  assign w_eff = (cfg.grid_width > SIDE_LIM) ? SIDE_LIM : cfg.grid_width;
  assign h_eff = (cfg.grid_height > SIDE_LIM) ? SIDE_LIM : cfg.grid_height;

  // query operands and transform registers
  logic signed [31:0] wx_r, wy_r;
  logic [31:0]        rad_r;
  logic signed [32:0] dx_r, dy_r;
  logic signed [33:0] ma, mb;
  logic signed [67:0] mul, prod_r;
  logic signed [50:0] sx_r, sy_r;
  logic [50:0]        ax_r, ay_r;
  logic               nx_r, ny_r;
  logic [63:0]        lo_r;
  logic [51:0]        q_r;
  logic               rem_r;
  logic signed [38:0] cx_r, cy_r;
  logic [RW-1:0]      rc_r;
  logic               off_r;
  logic [COST_W-1:0]  res_r;

  // scan state
  logic signed [OW-1:0] ox_r, oy_r;
  logic [DIM_W-1:0]     cxs_r, cys_r;
  logic                 a_v_r, a_disk_r, a_map_r;
  logic [DIM_W-1:0]     ax_s_r, ay_s_r;
  logic                 c_v_r, c_disk_r, c_ok_r;
  logic [RAW_W-1:0]     rdata_r;
  logic [COST_W-1:0]    best_r;
  logic [AW-1:0]        clr_r;

  // cell store
  logic [RAW_W-1:0] mem [MAX_CELLS];

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd)
      CMD_M1: begin ma = {{18{cfg.cos_yaw[15]}}, cfg.cos_yaw}; mb = {dx_r[32], dx_r}; end
      CMD_M2: begin ma = {{18{cfg.sin_yaw[15]}}, cfg.sin_yaw}; mb = {dy_r[32], dy_r}; end
      CMD_M3: begin ma = {{18{cfg.cos_yaw[15]}}, cfg.cos_yaw}; mb = {dy_r[32], dy_r}; end
      CMD_M4: begin ma = {{18{cfg.sin_yaw[15]}}, cfg.sin_yaw}; mb = {dx_r[32], dx_r}; end
      CMD_M5: begin ma = {2'b00, ax_r[31:0]};     mb = {2'b00, cfg.inverse_resolution}; end
      CMD_M6: begin ma = {15'd0, ax_r[50:32]};    mb = {2'b00, cfg.inverse_resolution}; end
      CMD_M7: begin ma = {2'b00, rad_r};          mb = {2'b00, cfg.inverse_resolution}; end
      CMD_M8: begin ma = {2'b00, ay_r[31:0]};     mb = {2'b00, cfg.inverse_resolution}; end
      CMD_M9: begin ma = {15'd0, ay_r[50:32]};    mb = {2'b00, cfg.inverse_resolution}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end
  assign mul = ma * mb;

  // floor of a signed magnitude quotient, with remainder folded in
  function automatic logic signed [38:0] finish_floor(input logic [51:0] q,
                                                      input logic rem, input logic neg);
    logic [38:0] f;
    logic        r;
    f = {1'b0, q[51:14]};
    r = rem || (q[13:0] != 14'd0);
    return neg ? (-$signed(f) - $signed({38'd0, r})) : $signed(f);
  endfunction

  // radius in cells: ceil of product high word, saturated
  logic [32:0] rc_ceil;
  assign rc_ceil = {1'b0, prod_r[63:32]} + {32'd0, (prod_r[31:0] != 32'd0)};

  // off-map test once both cell coordinates are known
  logic off_now;
  assign off_now = (w_eff == '0) || (h_eff == '0) || (cfg.inverse_resolution == 32'd0) ||
                   cx_r[38] || cy_r[38] ||
                   (cx_r[37:0] >= {29'd0, w_eff}) || (cy_r[37:0] >= {29'd0, h_eff});

  // arithmetic step registers
  always_ff @(posedge clk) begin
    prod_r <= mul;
    case (cmd)
      CMD_CAPTURE: begin
        wx_r  <= world_x;
        wy_r  <= world_y;
        rad_r <= radius;
      end
      CMD_SUB: begin
        dx_r <= {wx_r[31], wx_r} - {cfg.origin_x_pos[31], cfg.origin_x_pos};
        dy_r <= {wy_r[31], wy_r} - {cfg.origin_y_pos[31], cfg.origin_y_pos};
      end
      CMD_M2: sx_r <= prod_r[50:0];
      CMD_M3: sx_r <= sx_r + prod_r[50:0];
      CMD_M4: begin
        sy_r <= prod_r[50:0];
        nx_r <= sx_r[50];
        ax_r <= sx_r[50] ? 51'(-sx_r) : 51'(sx_r);
      end
      CMD_M5: sy_r <= sy_r - prod_r[50:0];
      CMD_M6: begin
        lo_r <= prod_r[63:0];
        ny_r <= sy_r[50];
        ay_r <= sy_r[50] ? 51'(-sy_r) : 51'(sy_r);
      end
      CMD_M7, CMD_M10: begin
        q_r   <= prod_r[51:0] + {20'd0, lo_r[63:32]};
        rem_r <= (lo_r[31:0] != 32'd0);
      end
      CMD_M8: begin
        cx_r <= finish_floor(q_r, rem_r, nx_r);
        rc_r <= (rc_ceil > {{(33-RW){1'b0}}, RMAX}) ? RMAX : rc_ceil[RW-1:0];
      end
      CMD_M9:  lo_r <= prod_r[63:0];
      CMD_M11: cy_r <= finish_floor(q_r, rem_r, ny_r);
      CMD_CHECK: begin
        off_r <= off_now;
        cxs_r <= cx_r[DIM_W-1:0];
        cys_r <= cy_r[DIM_W-1:0];
      end
      CMD_RESULT: res_r <= off_r ? LETHAL_COST : best_r;
      default: ;
    endcase
  end

  // scan counters
  logic signed [OW-1:0] r_s;
  logic                 ox_end, oy_end;
  assign r_s    = $signed({1'b0, rc_r});
  assign ox_end = (ox_r == r_s);
  assign oy_end = (oy_r == r_s);

  always_ff @(posedge clk) begin
    if (cmd == CMD_CHECK) begin
      ox_r <= -r_s;
      oy_r <= -r_s;
    end else if (cmd == CMD_SCAN) begin
      if (ox_end) begin
        ox_r <= -r_s;
        oy_r <= oy_r + OW'(1);
      end else begin
        ox_r <= ox_r + OW'(1);
      end
    end
  end

  // stage a: cell coordinates, map and disk membership
  logic signed [10:0] xs, ys;
  logic [RW-1:0]      mx, my;
  logic [2*RW-1:0]    mx2, my2;
  logic [2*RW:0]      d2;
  logic [2*RW-1:0]    rr;
  assign xs  = $signed({2'b00, cxs_r}) + $signed({{(11-OW){ox_r[OW-1]}}, ox_r});
  assign ys  = $signed({2'b00, cys_r}) + $signed({{(11-OW){oy_r[OW-1]}}, oy_r});
  assign mx  = ox_r[OW-1] ? RW'(-ox_r) : ox_r[RW-1:0];
  assign my  = oy_r[OW-1] ? RW'(-oy_r) : oy_r[RW-1:0];
  assign mx2 = mx * mx;
  assign my2 = my * my;
  assign d2  = {1'b0, mx2} + {1'b0, my2};
  assign rr  = rc_r * rc_r;

  // stage b: row-major address
  logic [IDX_W-1:0]    idx;
  logic [AW+IDX_W-1:0] idx_ext;
  logic [AW+15:0]      ld_ext;
  logic                b_ok, ld_ok, we;
  logic [AW-1:0]       waddr;
  logic [RAW_W-1:0]    wdata;
  assign idx     = ay_s_r * w_eff + {{DIM_W{1'b0}}, ax_s_r};
  assign idx_ext = {{AW{1'b0}}, idx};
  assign b_ok    = a_map_r && ({7'd0, idx} < CELLS_LIM);
  assign ld_ext  = {{AW{1'b0}}, cell_index};
  assign ld_ok   = ({9'd0, cell_index} < CELLS_LIM);

  // store write port: clearing pass or load
  always_comb begin
    we    = 1'b0;
    waddr = clr_r;
    wdata = UNKNOWN_RAW;
    if (cmd == CMD_CLEAR) begin
      we = 1'b1;
    end else if (cmd == CMD_LOAD && ld_ok) begin
      we    = 1'b1;
      waddr = ld_ext[AW-1:0];
      wdata = cell_value;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[idx_ext[AW-1:0]];
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    a_disk_r <= ({1'b0, rr} >= d2);
    a_map_r  <= !xs[10] && !ys[10] && (xs[9:0] < {1'b0, w_eff}) && (ys[9:0] < {1'b0, h_eff});
    ax_s_r   <= xs[DIM_W-1:0];
    ay_s_r   <= ys[DIM_W-1:0];
    c_disk_r <= a_disk_r;
    c_ok_r   <= b_ok;
  end

  // stage c: running maximum
  logic [COST_W-1:0] contrib;
  assign contrib = c_ok_r ? clamp_cost(rdata_r) : LETHAL_COST;

  // pipeline valids, clear counter and best cost
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r  <= 1'b0;
      c_v_r  <= 1'b0;
      clr_r  <= '0;
      best_r <= '0;
    end else begin
      a_v_r <= (cmd == CMD_SCAN);
      c_v_r <= a_v_r;
      if (cmd == CMD_CLEAR) clr_r <= clr_r + AW'(1);
      if (cmd == CMD_CHECK) begin
        best_r <= '0;
      end else if (c_v_r && c_disk_r && (contrib > best_r)) begin
        best_r <= contrib;
      end
    end
  end

  assign stat.clr_last  = (clr_r == CLR_LAST);
  assign stat.off_map   = off_now;
  assign stat.scan_last = ox_end && oy_end;
  assign cost           = res_r;

endmodule
